>>> design/iee_pkg.sv
`timescale 1ns / 1ps

package iee_pkg;

    localparam int VALUE_DEPTH_DEF    = 16;
    localparam int OPERATOR_DEPTH_DEF = 16;
    localparam int DATA_W             = 32;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        OPC_LPAREN = 3'd0,
        OPC_ADD    = 3'd1,
        OPC_SUB    = 3'd2,
        OPC_MUL    = 3'd3,
        OPC_DIV    = 3'd4
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHAR,
        S_OPS,
        S_RPAR_RD,
        S_RPAR_CHK,
        S_OP_RD,
        S_OP_CHK,
        S_RED,
        S_RED_B,
        S_RED_A,
        S_RED_WAIT,
        S_END,
        S_FIN_FLUSH,
        S_FIN_RD,
        S_FIN_OP,
        S_FIN_CHK,
        S_FIN_VAL
    } state_t;

    typedef struct packed {
        logic     start;
        op_code_t op;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic div_zero;
    } alu_stat_t;

    function automatic logic [1:0] prec_of(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            OPC_ADD, OPC_SUB: p = 2'd1;
            OPC_MUL, OPC_DIV: p = 2'd2;
            default:          p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic op_code_t char_to_op(input logic [7:0] c);
        op_code_t o;
        case (c)
            CH_PLUS:  o = OPC_ADD;
            CH_MINUS: o = OPC_SUB;
            CH_STAR:  o = OPC_MUL;
            CH_SLASH: o = OPC_DIV;
            default:  o = OPC_LPAREN;
        endcase
        return o;
    endfunction

endpackage

>>> design/iee_ram.sv
`timescale 1ns / 1ps

module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/iee_alu.sv
`timescale 1ns / 1ps

module iee_alu (
    input  logic                    clk,
    input  logic                    rst_n,
    input  iee_pkg::alu_ctl_t       ctl,
    input  logic [31:0]             a,
    input  logic [31:0]             b,
    output iee_pkg::alu_stat_t      stat,
    output logic [31:0]             res
);

    import iee_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        dz_reg, dz_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] mb_reg, mb_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;

    logic [32:0] trial;
    logic        ge;
    logic [31:0] quo_step;
    logic [31:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            dz_reg   <= dz_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    // one restoring step per cycle on the magnitudes
    assign trial    = {rem_reg, quo_reg[31]} - {1'b0, mb_reg};
    assign ge       = ({rem_reg, quo_reg[31]} >= {1'b0, mb_reg});
    assign quo_step = {quo_reg[30:0], ge};
    // only the low word of the product is kept
    assign prod     = a * b;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        dz_next   = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        if (busy_reg)
        begin
            rem_next = ge ? trial[31:0] : {rem_reg[30:0], quo_reg[31]};
            quo_next = quo_step;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (32'd0 - quo_step) : quo_step;
            end
        end
        else if (ctl.start)
        begin
            case (ctl.op)
                OPC_ADD:
                begin
                    res_next  = a + b;
                    done_next = 1'b1;
                end
                OPC_SUB:
                begin
                    res_next  = a - b;
                    done_next = 1'b1;
                end
                OPC_MUL:
                begin
                    res_next  = prod;
                    done_next = 1'b1;
                end
                OPC_DIV:
                begin
                    if (b == 32'd0)
                    begin
                        done_next = 1'b1;
                        dz_next   = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        cnt_next  = '0;
                        rem_next  = '0;
                        quo_next  = a[31] ? (32'd0 - a) : a;
                        mb_next   = b[31] ? (32'd0 - b) : b;
                        neg_next  = a[31] ^ b[31];
                    end
                end
                default:
                begin
                    res_next  = '0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.div_zero = dz_reg;
    assign res           = res_reg;

    property p_start_idle;
        @(posedge clk) disable iff (!rst_n) ctl.start |-> !busy_reg;
    endproperty
    a_start_idle: assert property (p_start_idle) else $error("alu started while busy");

    property p_dz_done;
        @(posedge clk) disable iff (!rst_n) dz_reg |-> done_reg;
    endproperty
    a_dz_done: assert property (p_dz_done) else $error("divide by zero without done");

    property p_done_not_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg;
    endproperty
    a_done_not_busy: assert property (p_done_not_busy) else $error("done while busy");

endmodule

>>> design/infix_expression_evaluator_unit.sv
`timescale 1ns / 1ps

// Evaluates an infix expression (+ - * / with parentheses, decimal numbers,
// 32-bit wrapping arithmetic, division toward zero) fed one character per beat;
// the beat with last set yields one result beat with a status code. The unit
// takes one character at a time: a digit, a skipped character or any character
// after an error needs no arithmetic, an operator or parenthesis may start
// reductions, and the final character also pushes any pending number and
// reduces the operators left on the stack. Each reduction goes through the
// shared arithmetic unit; its restoring divider resolves one quotient bit per
// cycle. Stacks live in two single-port-read RAMs with registered reads.
module infix_expression_evaluator_unit #(
    parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
    parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  ch,
    input  logic        last,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] result,
    output logic [1:0]  status,
    output logic        out_valid,
    input  logic        out_stall
);

    import iee_pkg::*;

    localparam int VAW = $clog2(VALUE_DEPTH);
    localparam int VCW = $clog2(VALUE_DEPTH + 1);
    localparam int OAW = $clog2(OPERATOR_DEPTH);
    localparam int OCW = $clog2(OPERATOR_DEPTH + 1);
    localparam logic [VCW-1:0] VFULL = VCW'(VALUE_DEPTH);
    localparam logic [OCW-1:0] OFULL = OCW'(OPERATOR_DEPTH);

    state_t          state_reg, state_next;
    state_t          ret_reg, ret_next;
    logic [VCW-1:0]  vcnt_reg, vcnt_next;
    logic [OCW-1:0]  ocnt_reg, ocnt_next;
    logic [31:0]     acc_reg, acc_next;
    logic            innum_reg, innum_next;
    status_t         err_reg, err_next;
    logic [7:0]      ch_reg, ch_next;
    logic            last_reg, last_next;
    op_code_t        op_reg, op_next;
    logic [31:0]     b_reg, b_next;
    logic            ovalid_reg, ovalid_next;
    logic [31:0]     res_reg, res_next;
    status_t         stat_reg, stat_next;

    logic            v_we;
    logic [VAW-1:0]  v_waddr, v_raddr;
    logic [31:0]     v_wdata, v_rdata;
    logic            o_we;
    logic [OAW-1:0]  o_waddr, o_raddr;
    logic [2:0]      o_wdata, o_rdata;

    alu_ctl_t        alu_ctl;
    alu_stat_t       alu_stat;
    logic [31:0]     alu_res;

    logic [VCW-1:0]  vm1, vm2;
    logic [OCW-1:0]  om1;
    logic            is_digit;
    logic [31:0]     acc_mul;
    op_code_t        ch_op;

    assign vm1      = vcnt_reg - VCW'(1);
    assign vm2      = vcnt_reg - VCW'(2);
    assign om1      = ocnt_reg - OCW'(1);
    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign acc_mul  = (acc_reg << 3) + (acc_reg << 1) + {24'd0, ch_reg - CH_ZERO};
    assign ch_op    = char_to_op(ch_reg);
    assign o_raddr  = om1[OAW-1:0];

    iee_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vstack (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_ostack (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    iee_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (alu_ctl),
        .a     (v_rdata),
        .b     (b_reg),
        .stat  (alu_stat),
        .res   (alu_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            vcnt_reg   <= '0;
            ocnt_reg   <= '0;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            err_reg    <= ST_OK;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            vcnt_reg   <= vcnt_next;
            ocnt_reg   <= ocnt_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            err_reg    <= err_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        op_reg   <= op_next;
        b_reg    <= b_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        vcnt_next   = vcnt_reg;
        ocnt_next   = ocnt_reg;
        acc_next    = acc_reg;
        innum_next  = innum_reg;
        err_next    = err_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        op_next     = op_reg;
        b_next      = b_reg;
        res_next    = res_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg && out_stall;
        v_we        = 1'b0;
        v_waddr     = vcnt_reg[VAW-1:0];
        v_wdata     = acc_reg;
        v_raddr     = vm1[VAW-1:0];
        o_we        = 1'b0;
        o_waddr     = ocnt_reg[OAW-1:0];
        o_wdata     = OPC_LPAREN;
        alu_ctl     = '{start: 1'b0, op: op_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ch_next    = ch;
                    last_next  = last;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (err_reg != ST_OK)
                begin
                    state_next = S_END;
                end
                else if (is_digit)
                begin
                    acc_next   = acc_mul;
                    innum_next = 1'b1;
                    state_next = S_END;
                end
                else
                begin
                    if (innum_reg)
                    begin
                        innum_next = 1'b0;
                        acc_next   = '0;
                        if (vcnt_reg == VFULL)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            v_we      = 1'b1;
                            vcnt_next = vcnt_reg + VCW'(1);
                        end
                    end
                    state_next = S_OPS;
                end
            end
            S_OPS:
            begin
                state_next = S_END;
                if (err_reg == ST_OK)
                begin
                    if (ch_reg == CH_LPAREN)
                    begin
                        if (ocnt_reg == OFULL)
                        begin
                            err_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            o_we      = 1'b1;
                            ocnt_next = ocnt_reg + OCW'(1);
                        end
                    end
                    else if (ch_reg == CH_RPAREN)
                    begin
                        state_next = S_RPAR_RD;
                    end
                    else if (ch_op != OPC_LPAREN)
                    begin
                        state_next = S_OP_RD;
                    end
                end
            end
            S_RPAR_RD:
            begin
                if (err_reg != ST_OK)
                begin
                    state_next = S_END;
                end
                else if (ocnt_reg == '0)
                begin
                    err_next   = ST_MALFORMED;
                    state_next = S_END;
                end
                else
                begin
                    state_next = S_RPAR_CHK;
                end
            end
            S_RPAR_CHK:
            begin
                if (o_rdata == OPC_LPAREN)
                begin
                    ocnt_next  = om1;
                    state_next = S_END;
                end
                else
                begin
                    ret_next   = S_RPAR_RD;
                    state_next = S_RED;
                end
            end
            S_OP_RD:
            begin
                if (err_reg != ST_OK)
                begin
                    state_next = S_END;
                end
                else if (ocnt_reg == '0)
                begin
                    state_next = S_OP_CHK;
                end
                else
                begin
                    state_next = S_OP_CHK;
                end
            end
            S_OP_CHK:
            begin
                if (ocnt_reg != '0 && prec_of(o_rdata) >= prec_of(ch_op))
                begin
                    ret_next   = S_OP_RD;
                    state_next = S_RED;
                end
                else
                begin
                    state_next = S_END;
                    if (ocnt_reg == OFULL)
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        o_we      = 1'b1;
                        o_wdata   = ch_op;
                        ocnt_next = ocnt_reg + OCW'(1);
                    end
                end
            end
            S_RED:
            begin
                op_next = op_code_t'(o_rdata);
                if (vcnt_reg < VCW'(2))
                begin
                    err_next   = ST_MALFORMED;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_RED_B;
                end
            end
            S_RED_B:
            begin
                b_next     = v_rdata;
                v_raddr    = vm2[VAW-1:0];
                state_next = S_RED_A;
            end
            S_RED_A:
            begin
                if (op_reg == OPC_LPAREN || op_reg > OPC_DIV)
                begin
                    err_next   = ST_MALFORMED;
                    state_next = ret_reg;
                end
                else
                begin
                    alu_ctl.start = 1'b1;
                    state_next    = S_RED_WAIT;
                end
            end
            S_RED_WAIT:
            begin
                if (alu_stat.done)
                begin
                    ocnt_next  = om1;
                    vcnt_next  = vm1;
                    state_next = ret_reg;
                    if (alu_stat.div_zero)
                    begin
                        err_next = ST_DIVZERO;
                    end
                    else
                    begin
                        v_we    = 1'b1;
                        v_waddr = vm2[VAW-1:0];
                        v_wdata = alu_res;
                    end
                end
            end
            S_END:
            begin
                state_next = last_reg ? S_FIN_FLUSH : S_IDLE;
            end
            S_FIN_FLUSH:
            begin
                if (err_reg == ST_OK && innum_reg)
                begin
                    if (vcnt_reg == VFULL)
                    begin
                        err_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        v_we      = 1'b1;
                        vcnt_next = vcnt_reg + VCW'(1);
                    end
                end
                state_next = S_FIN_RD;
            end
            S_FIN_RD:
            begin
                if (err_reg != ST_OK || ocnt_reg == '0)
                begin
                    state_next = S_FIN_CHK;
                end
                else
                begin
                    state_next = S_FIN_OP;
                end
            end
            S_FIN_OP:
            begin
                if (o_rdata == OPC_LPAREN)
                begin
                    err_next   = ST_MALFORMED;
                    state_next = S_FIN_CHK;
                end
                else
                begin
                    ret_next   = S_FIN_RD;
                    state_next = S_RED;
                end
            end
            S_FIN_CHK:
            begin
                if (err_reg == ST_OK && vcnt_reg == '0)
                begin
                    err_next = ST_MALFORMED;
                end
                state_next = S_FIN_VAL;
            end
            S_FIN_VAL:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    res_next    = (err_reg == ST_OK) ? v_rdata : 32'd0;
                    stat_next   = err_reg;
                    ovalid_next = 1'b1;
                    vcnt_next   = '0;
                    ocnt_next   = '0;
                    acc_next    = '0;
                    innum_next  = 1'b0;
                    err_next    = ST_OK;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;
    assign result    = res_reg;
    assign status    = stat_reg;

    property p_vcnt_range;
        @(posedge clk) disable iff (!rst_n) vcnt_reg <= VFULL;
    endproperty
    a_vcnt_range: assert property (p_vcnt_range) else $error("value count past depth");

    property p_ocnt_range;
        @(posedge clk) disable iff (!rst_n) ocnt_reg <= OFULL;
    endproperty
    a_ocnt_range: assert property (p_ocnt_range) else $error("operator count past depth");

    property p_alu_busy_wait;
        @(posedge clk) disable iff (!rst_n) alu_stat.busy |-> state_reg == S_RED_WAIT;
    endproperty
    a_alu_busy_wait: assert property (p_alu_busy_wait) else $error("divider busy outside wait");

    property p_clear_after_result;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == S_FIN_VAL && state_next == S_IDLE)
            |=> (vcnt_reg == '0 && ocnt_reg == '0 && err_reg == ST_OK && out_valid);
    endproperty
    a_clear_after_result: assert property (p_clear_after_result)
        else $error("state not cleared after result");

endmodule
